// File: src/stwrd_pkg.sv
// ---------------------------------------------------------------------------
// Slot table package
// Field widths, request and status codes, and the command and status
// bundles passed between the controller and the datapath.
// ---------------------------------------------------------------------------
package stwrd_pkg;

   // Port field widths.
   localparam int TYPE_W   = 3;
   localparam int SLOT_W   = 10;
   localparam int DATA_W   = 32;
   localparam int STATUS_W = 3;
   localparam int COUNT_W  = 11;
   localparam int CSR_W    = 16;

   // The occupancy bitmap is held as words of MAP_W bits.
   localparam int MAP_W  = 32;
   localparam int MAP_SH = 5;

   localparam logic [CSR_W-1:0] MAX_IN_USE_RESET = 16'd1024;

   // Request codes.
   localparam logic [TYPE_W-1:0] REQ_ADD       = 3'd0;
   localparam logic [TYPE_W-1:0] REQ_DELETE    = 3'd1;
   localparam logic [TYPE_W-1:0] REQ_SET_OCC   = 3'd2;
   localparam logic [TYPE_W-1:0] REQ_SET_EMPTY = 3'd3;
   localparam logic [TYPE_W-1:0] REQ_READ      = 3'd4;
   localparam logic [TYPE_W-1:0] REQ_DRAW      = 3'd5;

   // Status codes.
   localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
   localparam logic [STATUS_W-1:0] ST_NO_SPACE = 3'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd2;
   localparam logic [STATUS_W-1:0] ST_BUSY     = 3'd3;
   localparam logic [STATUS_W-1:0] ST_RANGE    = 3'd4;
   localparam logic [STATUS_W-1:0] ST_MISS     = 3'd5;

   typedef struct packed {
      logic capture;    // take a new item from the request ports
      logic prep;       // load address and draw product
      logic load_k;     // address takes the scaled draw index
      logic scan_init;  // start the free-slot scan at the row of the count
      logic scan_next;  // move the scan to the next row
      logic scan_to_b;  // restart the scan from row zero
      logic scan_rd;    // read the bitmap row under scan
      logic take_hit;   // address takes the free slot found by the scan
      logic set_fail;   // the add finds no space
      logic mem_rd;     // read slot and bitmap row at the address
      logic exec;       // update the table and issue the result
   } ctrl_cmd_type;

   typedef struct packed {
      logic is_add;
      logic is_draw;
      logic add_search;
      logic add_full;
      logic scan_hit;
      logic scan_last;
      logic scan_b;
      logic occ_zero;
   } ctrl_stat_type;

endpackage

// File: src/stwrd_ctrl.sv
// ---------------------------------------------------------------------------
// Slot table controller
// Sequences each item through preparation, the free-slot scan for adds,
// the memory read and the update step.
// ---------------------------------------------------------------------------
module stwrd_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   output stwrd_pkg::ctrl_cmd_type  cmd,
   input  stwrd_pkg::ctrl_stat_type stat
);
   import stwrd_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_PREP,
      S_KSEL,
      S_SCAN_RD,
      S_SCAN_CK,
      S_MEM_RD,
      S_EXEC
   } state_type;

   state_type state_ff, state_in;
   logic      busy_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               state_in    = S_PREP;
            end
         end
         S_PREP: begin
            cmd.prep = 1'b1;
            if (stat.is_add) begin
               if (stat.add_search) begin
                  cmd.scan_init = 1'b1;
                  state_in      = S_SCAN_RD;
               end else begin
                  cmd.set_fail = stat.add_full;
                  state_in     = S_MEM_RD;
               end
            end else if (stat.is_draw) begin
               state_in = S_KSEL;
            end else begin
               state_in = S_MEM_RD;
            end
         end
         S_KSEL: begin
            cmd.load_k = 1'b1;
            state_in   = S_MEM_RD;
         end
         S_SCAN_RD: begin
            cmd.scan_rd = 1'b1;
            state_in    = S_SCAN_CK;
         end
         S_SCAN_CK: begin
            if (stat.scan_hit) begin
               cmd.take_hit = 1'b1;
               state_in     = S_MEM_RD;
            end else if (!stat.scan_last) begin
               cmd.scan_next = 1'b1;
               state_in      = S_SCAN_RD;
            end else if (!stat.scan_b && !stat.occ_zero) begin
               // Nothing free from the count up to the length: wrap to slot zero.
               cmd.scan_to_b = 1'b1;
               state_in      = S_SCAN_RD;
            end else begin
               cmd.set_fail = 1'b1;
               state_in     = S_MEM_RD;
            end
         end
         S_MEM_RD: begin
            cmd.mem_rd = 1'b1;
            state_in   = S_EXEC;
         end
         S_EXEC: begin
            cmd.exec = 1'b1;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         busy_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         busy_ff  <= (state_in != S_IDLE);
      end
   end

   assign busy = busy_ff;

endmodule

// File: src/stwrd_dp.sv
// ---------------------------------------------------------------------------
// Slot table datapath
// Slot memory, occupancy bitmap memory with per-row valid bits, counters,
// draw multiplier, free-slot row encoder and result registers.
// ---------------------------------------------------------------------------
module stwrd_dp #(
   parameter int DEPTH      = 1024,
   parameter int VALUE_BITS = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  stwrd_pkg::ctrl_cmd_type              cmd,
   output stwrd_pkg::ctrl_stat_type             stat,
   input  logic [stwrd_pkg::TYPE_W-1:0]         req_type,
   input  logic [stwrd_pkg::SLOT_W-1:0]         req_slot_index,
   input  logic [stwrd_pkg::DATA_W-1:0]         req_entry_value,
   input  logic [stwrd_pkg::DATA_W-1:0]         req_random_fraction,
   input  logic                                 csr_wr_en,
   input  logic [stwrd_pkg::CSR_W-1:0]          csr_wr_data,
   output logic                                 rsp_valid,
   output logic [stwrd_pkg::DATA_W-1:0]         rsp_result_value,
   output logic [stwrd_pkg::STATUS_W-1:0]       rsp_status,
   output logic [stwrd_pkg::COUNT_W-1:0]        rsp_occupied_count,
   output logic [stwrd_pkg::COUNT_W-1:0]        rsp_used_length
);
   import stwrd_pkg::*;

   localparam int IDX_W  = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int WIDE_W = (CNT_W > CSR_W) ? CNT_W : CSR_W;
   localparam int ROWS   = (DEPTH + MAP_W - 1) / MAP_W;
   localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int PROD_W = DATA_W + WIDE_W;

   // Captured item.
   logic [TYPE_W-1:0]     type_ff;
   logic [SLOT_W-1:0]     idx_ff;
   logic [VALUE_BITS-1:0] val_ff;
   logic [DATA_W-1:0]     frac_ff;

   // Table state.
   logic [CNT_W-1:0]      occ_ff, occ_in;
   logic [CNT_W-1:0]      len_ff, len_in;
   logic [CSR_W-1:0]      max_ff;
   logic [ROWS-1:0]       rv_ff;

   // Working registers.
   logic [WIDE_W-1:0]     addr_ff;
   logic [PROD_W-1:0]     prod_ff;
   logic                  fail_ff;
   logic [ROW_W-1:0]      scan_row_ff;
   logic                  scan_b_ff;
   logic [MAP_W-1:0]      bm_rd_ff;
   logic                  rv_rd_ff;
   logic [VALUE_BITS-1:0] slot_rd_ff;
   logic                  rsp_valid_ff;
   logic [DATA_W-1:0]     rsp_value_ff, rsp_value_in;
   logic [STATUS_W-1:0]   rsp_status_ff, rsp_status_in;

   // Memories.
   logic [VALUE_BITS-1:0] slot_mem [DEPTH];
   logic [MAP_W-1:0]      bm_mem [ROWS];

   logic [WIDE_W-1:0]     occ_w, len_w, idx_w, occ_m1, len_m1, scale_n, draw_k;
   logic [ROW_W-1:0]      addr_row, rd_row, occ_row;
   logic [MAP_SH-1:0]     addr_bit, hit_bit;
   logic [MAP_W-1:0]      row_eff, hit, wr_row;
   logic                  cur_bit, len_mode, val_nz, wr, wbit;
   logic [VALUE_BITS-1:0] slot_val;
   logic [CNT_W-1:0]      occ_up, occ_dn;

   assign occ_w    = WIDE_W'(occ_ff);
   assign len_w    = WIDE_W'(len_ff);
   assign idx_w    = WIDE_W'(idx_ff);
   assign occ_m1   = occ_w - WIDE_W'(1);
   assign len_m1   = len_w - WIDE_W'(1);
   assign occ_row  = occ_w[MAP_SH +: ROW_W];
   assign addr_row = addr_ff[MAP_SH +: ROW_W];
   assign addr_bit = addr_ff[MAP_SH-1:0];
   assign rd_row   = cmd.mem_rd ? addr_row : scan_row_ff;

   // Length mode when the nominal capacity is already reached.
   assign len_mode = WIDE_W'(max_ff) <= occ_w;
   assign scale_n  = len_mode ? len_w : WIDE_W'(max_ff);
   assign draw_k   = prod_ff[DATA_W +: WIDE_W];

   // A bitmap row never written reads as all empty.
   assign row_eff  = rv_rd_ff ? bm_rd_ff : '0;
   assign cur_bit  = row_eff[addr_bit];
   assign slot_val = cur_bit ? slot_rd_ff : '0;
   assign val_nz   = |val_ff;

   assign occ_up = (occ_ff < CNT_W'(DEPTH)) ? occ_ff + CNT_W'(1) : occ_ff;
   assign occ_dn = (occ_ff != '0) ? occ_ff - CNT_W'(1) : occ_ff;

   // Free slots of the row under scan, limited to the current search window.
   always_comb begin
      logic [WIDE_W-1:0] pos;
      hit     = '0;
      hit_bit = '0;
      for (int i = 0; i < MAP_W; i++) begin
         pos = WIDE_W'({scan_row_ff, MAP_SH'(i)});
         if (scan_b_ff) begin
            hit[i] = !row_eff[i] && (pos < occ_w);
         end else begin
            hit[i] = !row_eff[i] && (pos >= occ_w) && (pos < len_w);
         end
      end
      for (int i = MAP_W - 1; i >= 0; i--) begin
         if (hit[i]) begin
            hit_bit = MAP_SH'(i);
         end
      end
   end

   always_comb begin
      stat.is_add     = (type_ff == REQ_ADD);
      stat.is_draw    = (type_ff == REQ_DRAW);
      stat.add_search = (len_ff > occ_ff);
      stat.add_full   = (len_w >= WIDE_W'(DEPTH));
      stat.scan_hit   = |hit;
      stat.scan_last  = scan_b_ff ? (scan_row_ff == occ_m1[MAP_SH +: ROW_W])
                                  : (scan_row_ff == len_m1[MAP_SH +: ROW_W]);
      stat.scan_b     = scan_b_ff;
      stat.occ_zero   = (occ_ff == '0);
   end

   // Outcome of the item at the update step.
   always_comb begin
      rsp_status_in = ST_OK;
      rsp_value_in  = '0;
      wr            = 1'b0;
      wbit          = val_nz;
      occ_in        = occ_ff;
      len_in        = len_ff;
      case (type_ff)
         REQ_ADD: begin
            if (fail_ff) begin
               rsp_status_in = ST_NO_SPACE;
            end else begin
               wr           = 1'b1;
               rsp_value_in = DATA_W'(addr_ff);
               occ_in       = occ_up;
               if (addr_ff == len_w) begin
                  len_in = CNT_W'(addr_ff) + CNT_W'(1);
               end
            end
         end
         REQ_DELETE: begin
            if (idx_w >= len_w) begin
               rsp_status_in = ST_RANGE;
            end else if (!cur_bit) begin
               rsp_status_in = ST_EMPTY;
            end else begin
               wr     = 1'b1;
               wbit   = 1'b0;
               occ_in = occ_dn;
            end
         end
         REQ_SET_OCC: begin
            if (idx_w >= len_w) begin
               rsp_status_in = ST_RANGE;
            end else if (!cur_bit) begin
               rsp_status_in = ST_EMPTY;
            end else begin
               wr = 1'b1;
            end
         end
         REQ_SET_EMPTY: begin
            if (idx_w >= WIDE_W'(DEPTH)) begin
               rsp_status_in = ST_RANGE;
            end else if (cur_bit) begin
               rsp_status_in = ST_BUSY;
            end else begin
               wr     = 1'b1;
               occ_in = occ_up;
               if (idx_w >= len_w) begin
                  len_in = CNT_W'(idx_w + WIDE_W'(1));
               end
            end
         end
         REQ_READ: begin
            if (idx_w >= len_w) begin
               rsp_status_in = ST_RANGE;
            end else begin
               rsp_value_in = DATA_W'(slot_val);
            end
         end
         REQ_DRAW: begin
            if (len_mode) begin
               if (len_ff == '0 || !cur_bit) begin
                  rsp_status_in = ST_MISS;
               end else begin
                  rsp_value_in = DATA_W'(slot_val);
               end
            end else if (addr_ff < len_w) begin
               rsp_value_in = DATA_W'(slot_val);
            end
         end
         default: begin
            rsp_status_in = ST_RANGE;
         end
      endcase
      wr_row           = row_eff;
      wr_row[addr_bit] = wbit;
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff       <= '0;
         len_ff       <= '0;
         max_ff       <= MAX_IN_USE_RESET;
         fail_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         rv_ff        <= '0;
      end else begin
         if (csr_wr_en) begin
            max_ff <= csr_wr_data;
         end
         rsp_valid_ff <= cmd.exec;
         if (cmd.capture) begin
            fail_ff <= 1'b0;
         end else if (cmd.set_fail) begin
            fail_ff <= 1'b1;
         end
         if (cmd.exec) begin
            occ_ff <= occ_in;
            len_ff <= len_in;
            if (wr) begin
               rv_ff[addr_row] <= 1'b1;
            end
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         type_ff <= req_type;
         idx_ff  <= req_slot_index;
         val_ff  <= VALUE_BITS'(req_entry_value);
         frac_ff <= req_random_fraction;
      end
      if (cmd.prep) begin
         prod_ff <= PROD_W'(frac_ff) * PROD_W'(scale_n);
         addr_ff <= stat.is_add ? len_w : idx_w;
      end else if (cmd.load_k) begin
         addr_ff <= draw_k;
      end else if (cmd.take_hit) begin
         addr_ff <= WIDE_W'({scan_row_ff, hit_bit});
      end
      if (cmd.scan_init) begin
         scan_row_ff <= occ_row;
         scan_b_ff   <= 1'b0;
      end else if (cmd.scan_to_b) begin
         scan_row_ff <= '0;
         scan_b_ff   <= 1'b1;
      end else if (cmd.scan_next) begin
         scan_row_ff <= scan_row_ff + ROW_W'(1);
      end
      if (cmd.exec) begin
         rsp_value_ff  <= rsp_value_in;
         rsp_status_ff <= rsp_status_in;
      end
   end

   // Slot memory.
   always_ff @(posedge clock) begin
      if (cmd.mem_rd) begin
         slot_rd_ff <= slot_mem[addr_ff[IDX_W-1:0]];
      end
      if (cmd.exec && wr) begin
         slot_mem[addr_ff[IDX_W-1:0]] <= val_ff;
      end
   end

   // Occupancy bitmap memory.
   always_ff @(posedge clock) begin
      if (cmd.mem_rd || cmd.scan_rd) begin
         bm_rd_ff <= bm_mem[rd_row];
         rv_rd_ff <= rv_ff[rd_row];
      end
      if (cmd.exec && wr) begin
         bm_mem[addr_row] <= wr_row;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_result_value   = rsp_value_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_occupied_count = COUNT_W'(occ_ff);
   assign rsp_used_length    = COUNT_W'(len_ff);

   // Each item passes from capture through the memory read to the update step, so result strobes never touch.
   a_strobe_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |=> !rsp_valid_ff)
      else $error("result strobe held for more than one cycle");

   // The used length is a high-water mark.
   a_len_grows: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> len_ff >= $past(len_ff))
      else $error("used length decreased");

   // Counters move only with the result of the item that moved them.
   a_cnt_with_rsp: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && (!$stable(occ_ff) || !$stable(len_ff))) |-> rsp_valid_ff)
      else $error("counter changed without a result");

endmodule

// File: src/slot_table_with_random_draw.sv
// ---------------------------------------------------------------------------
// Slot table with random draw
// Top level: controller and datapath of a value table with add, delete,
// set, read and random draw requests.
// ---------------------------------------------------------------------------
// An item is taken when start is high while busy is low; its result shows on
// the rsp_ ports for exactly one cycle with rsp_valid, and the receiver must
// take it then, as it cannot stall the block. Delete, set and read items
// pass through preparation, the memory read and the update step before the
// result strobe; a draw adds a step that loads the address with the scaled
// index from the fraction multiply. An add that appends skips the scan; an
// add that must look for a gap scans the occupancy bitmap one 32-slot word
// at a time, a read then a check per word, at most ceil(DEPTH/32)+1 words.
// The table is empty straight out of reset, with no clearing pass. Write
// max_in_use only while busy is low and no result is pending.
// ---------------------------------------------------------------------------
module slot_table_with_random_draw #(
   parameter int DEPTH      = 1024,
   parameter int VALUE_BITS = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic [stwrd_pkg::TYPE_W-1:0]   req_type,
   input  logic [stwrd_pkg::SLOT_W-1:0]   req_slot_index,
   input  logic [stwrd_pkg::DATA_W-1:0]   req_entry_value,
   input  logic [stwrd_pkg::DATA_W-1:0]   req_random_fraction,
   output logic                           rsp_valid,
   output logic [stwrd_pkg::DATA_W-1:0]   rsp_result_value,
   output logic [stwrd_pkg::STATUS_W-1:0] rsp_status,
   output logic [stwrd_pkg::COUNT_W-1:0]  rsp_occupied_count,
   output logic [stwrd_pkg::COUNT_W-1:0]  rsp_used_length,
   input  logic                           csr_wr_en,
   input  logic [stwrd_pkg::CSR_W-1:0]    csr_wr_data
);
   import stwrd_pkg::*;

   ctrl_cmd_type  cmd;
   ctrl_stat_type stat;

   stwrd_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .cmd   (cmd),
      .stat  (stat)
   );

   stwrd_dp #(
      .DEPTH      (DEPTH),
      .VALUE_BITS (VALUE_BITS)
   ) u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .stat                (stat),
      .req_type            (req_type),
      .req_slot_index      (req_slot_index),
      .req_entry_value     (req_entry_value),
      .req_random_fraction (req_random_fraction),
      .csr_wr_en           (csr_wr_en),
      .csr_wr_data         (csr_wr_data),
      .rsp_valid           (rsp_valid),
      .rsp_result_value    (rsp_result_value),
      .rsp_status          (rsp_status),
      .rsp_occupied_count  (rsp_occupied_count),
      .rsp_used_length     (rsp_used_length)
   );

endmodule

// File: dv/tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Slot table with random draw: testbench
// Drives add, delete, set, read and draw items through the start/busy
// handshake with bursts and gaps, keeps its own image of the table to
// predict every result, and checks each strobed result field by field.
// ---------------------------------------------------------------------------
module tb;
   import stwrd_pkg::*;

   localparam int TBL_DEPTH   = 1024;
   localparam int CYCLE_LIMIT = 600000;
   localparam int TAIL_CYCLES = 100;

   // Request codes the block does not define; both must report a range error.
   localparam logic [TYPE_W-1:0] REQ_SPARE_A = 3'd6;
   localparam logic [TYPE_W-1:0] REQ_SPARE_B = 3'd7;

   typedef struct packed {
      logic [DATA_W-1:0]   value;
      logic [STATUS_W-1:0] status;
      logic [COUNT_W-1:0]  count;
      logic [COUNT_W-1:0]  length;
   } table_result_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic                busy;
   logic [TYPE_W-1:0]   req_type = '0;
   logic [SLOT_W-1:0]   req_slot_index = '0;
   logic [DATA_W-1:0]   req_entry_value = '0;
   logic [DATA_W-1:0]   req_random_fraction = '0;
   logic                rsp_valid;
   logic [DATA_W-1:0]   rsp_result_value;
   logic [STATUS_W-1:0] rsp_status;
   logic [COUNT_W-1:0]  rsp_occupied_count;
   logic [COUNT_W-1:0]  rsp_used_length;
   logic                csr_wr_en = 1'b0;
   logic [CSR_W-1:0]    csr_wr_data = '0;

   // Image of the table as the block should hold it.
   logic [DATA_W-1:0] slots_m [0:TBL_DEPTH-1];
   int unsigned       occ_m;
   int unsigned       len_m;
   logic [CSR_W-1:0]  max_in_use_m;

   table_result_type pending_results [$];
   int               err_count   = 0;
   int               cycle_count = 0;
   int               burst_left  = 0;

   slot_table_with_random_draw #(
      .DEPTH      (TBL_DEPTH),
      .VALUE_BITS (DATA_W)
   ) u_dut (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_type            (req_type),
      .req_slot_index      (req_slot_index),
      .req_entry_value     (req_entry_value),
      .req_random_fraction (req_random_fraction),
      .rsp_valid           (rsp_valid),
      .rsp_result_value    (rsp_result_value),
      .rsp_status          (rsp_status),
      .rsp_occupied_count  (rsp_occupied_count),
      .rsp_used_length     (rsp_used_length),
      .csr_wr_en           (csr_wr_en),
      .csr_wr_data         (csr_wr_data)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL slot_table_with_random_draw");
         $finish;
      end
   end

   function automatic void count_up();
      if (occ_m < TBL_DEPTH) occ_m++;
   endfunction

   // Applies one item to the table image and returns the result it causes.
   function automatic table_result_type apply_request(input logic [TYPE_W-1:0] kind,
                                                      input logic [SLOT_W-1:0] slot,
                                                      input logic [DATA_W-1:0] value,
                                                      input logic [DATA_W-1:0] frac);
      table_result_type r;
      int unsigned      idx;
      int unsigned      hit;
      int unsigned      k;
      bit               found;
      logic [63:0]      prod;
      r.value  = '0;
      r.status = ST_OK;
      idx      = 32'(slot);
      hit      = 0;
      found    = 1'b0;
      case (kind)
         REQ_ADD: begin
            if (len_m > occ_m) begin
               // Look for a gap from the count upward, then from slot 0.
               for (int unsigned i = occ_m; i < len_m && !found; i++) begin
                  if (slots_m[i] == '0) begin
                     found = 1'b1;
                     hit   = i;
                  end
               end
               for (int unsigned i = 0; i < occ_m && i < len_m && !found; i++) begin
                  if (slots_m[i] == '0) begin
                     found = 1'b1;
                     hit   = i;
                  end
               end
               if (found) begin
                  slots_m[hit] = value;
                  count_up();
                  r.value = hit;
               end else begin
                  r.status = ST_NO_SPACE;
               end
            end else if (len_m < TBL_DEPTH) begin
               r.value        = len_m;
               slots_m[len_m] = value;
               len_m++;
               count_up();
            end else begin
               r.status = ST_NO_SPACE;
            end
         end
         REQ_DELETE: begin
            if (idx >= len_m) begin
               r.status = ST_RANGE;
            end else if (slots_m[idx] == '0) begin
               r.status = ST_EMPTY;
            end else begin
               slots_m[idx] = '0;
               if (occ_m > 0) occ_m--;
            end
         end
         REQ_SET_OCC: begin
            if (idx >= len_m) r.status = ST_RANGE;
            else if (slots_m[idx] == '0) r.status = ST_EMPTY;
            else slots_m[idx] = value;
         end
         REQ_SET_EMPTY: begin
            if (slots_m[idx] != '0) begin
               r.status = ST_BUSY;
            end else begin
               if (idx >= len_m) len_m = idx + 1;
               slots_m[idx] = value;
               count_up();
            end
         end
         REQ_READ: begin
            if (idx >= len_m) r.status = ST_RANGE;
            else r.value = slots_m[idx];
         end
         REQ_DRAW: begin
            if (max_in_use_m <= occ_m) begin
               prod = 64'(frac) * 64'(len_m);
               k    = prod[63:32];
               if (len_m == 0 || k >= TBL_DEPTH || slots_m[k] == '0) r.status = ST_MISS;
               else r.value = slots_m[k];
            end else begin
               prod = 64'(frac) * 64'(max_in_use_m);
               k    = prod[63:32];
               if (k < len_m && k < TBL_DEPTH) r.value = slots_m[k];
            end
         end
         default: begin
            r.status = ST_RANGE;
         end
      endcase
      r.count  = occ_m[COUNT_W-1:0];
      r.length = len_m[COUNT_W-1:0];
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                  input logic [DATA_W-1:0] want);
      err_count++;
      $display("mismatch at cycle %0d: %s got %0h expected %0h",
               cycle_count, what, got, want);
   endtask

   always @(posedge clock) begin
      table_result_type exp_r;
      if (!reset && rsp_valid) begin
         if (pending_results.size() == 0) begin
            report_mismatch("result with no item outstanding", rsp_result_value, '0);
         end else begin
            exp_r = pending_results.pop_front();
            if (rsp_result_value !== exp_r.value)
               report_mismatch("result_value", rsp_result_value, exp_r.value);
            if (rsp_status !== exp_r.status)
               report_mismatch("status", DATA_W'(rsp_status), DATA_W'(exp_r.status));
            if (rsp_occupied_count !== exp_r.count)
               report_mismatch("occupied_count", DATA_W'(rsp_occupied_count),
                               DATA_W'(exp_r.count));
            if (rsp_used_length !== exp_r.length)
               report_mismatch("used_length", DATA_W'(rsp_used_length),
                               DATA_W'(exp_r.length));
         end
      end
   end

   // Sends one item in the current burst, opening a random gap first when
   // the burst has run out, and records the result it should cause.
   task automatic issue_request(input logic [TYPE_W-1:0] kind, input logic [SLOT_W-1:0] slot,
                                input logic [DATA_W-1:0] value,
                                input logic [DATA_W-1:0] frac);
      int               gap;
      table_result_type exp_r;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 16);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            @(negedge clock);
            start <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      burst_left--;
      @(negedge clock);
      req_type            <= kind;
      req_slot_index      <= slot;
      req_entry_value     <= value;
      req_random_fraction <= frac;
      start               <= 1'b1;
      do @(posedge clock); while (busy);
      exp_r = apply_request(kind, slot, value, frac);
      pending_results.insert(pending_results.size(), exp_r);
   endtask

   task automatic wait_table_idle();
      @(negedge clock);
      start      <= 1'b0;
      burst_left = 0;
      while (pending_results.size() != 0) @(posedge clock);
      while (busy) @(posedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic set_max_in_use(input logic [CSR_W-1:0] value);
      wait_table_idle();
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en    <= 1'b0;
      max_in_use_m = value;
   endtask

   function automatic logic [DATA_W-1:0] pick_value();
      int r;
      r = $urandom_range(0, 99);
      if (r < 10) return '0;
      if (r < 15) return '1;
      return $urandom;
   endfunction

   function automatic logic [DATA_W-1:0] pick_fraction();
      int r;
      r = $urandom_range(0, 99);
      if (r < 5) return '0;
      if (r < 10) return '1;
      return $urandom;
   endfunction

   task automatic run_random_mix(input int count, input int far_pct);
      int                r;
      int unsigned       near;
      logic [TYPE_W-1:0] kind;
      logic [SLOT_W-1:0] slot;
      repeat (count) begin
         r = $urandom_range(0, 99);
         if (r < 26) kind = REQ_ADD;
         else if (r < 40) kind = REQ_DELETE;
         else if (r < 50) kind = REQ_SET_OCC;
         else if (r < 60) kind = REQ_SET_EMPTY;
         else if (r < 73) kind = REQ_READ;
         else if (r < 97) kind = REQ_DRAW;
         else kind = r[0] ? REQ_SPARE_A : REQ_SPARE_B;
         // Set empty may only grow the table a little here, so the table
         // stays short until the fill test.
         near = (kind == REQ_SET_EMPTY) ? len_m + 8 : len_m + 2;
         if (near > TBL_DEPTH - 1) near = TBL_DEPTH - 1;
         if (kind != REQ_SET_EMPTY && $urandom_range(0, 99) < far_pct)
            slot = SLOT_W'($urandom);
         else
            slot = SLOT_W'($urandom_range(0, near));
         issue_request(kind, slot, pick_value(), pick_fraction());
      end
   endtask

   task automatic test_directed_edges();
      // Length mode on an empty table misses.
      set_max_in_use(16'd0);
      issue_request(REQ_DRAW, 10'd0, 32'd0, 32'h4000_0000);
      set_max_in_use(16'd1024);
      issue_request(REQ_READ, 10'd0, 32'd0, 32'd0);
      issue_request(REQ_DELETE, 10'd0, 32'd0, 32'd0);
      issue_request(REQ_SET_OCC, 10'd0, 32'h1, 32'd0);
      issue_request(REQ_DRAW, 10'd0, 32'd0, 32'hFFFF_FFFF);
      issue_request(REQ_ADD, 10'd0, 32'hFFFF_FFFF, 32'd0);
      // A zero value is stored and still counts.
      issue_request(REQ_ADD, 10'd0, 32'd0, 32'd0);
      issue_request(REQ_READ, 10'd0, 32'd0, 32'd0);
      issue_request(REQ_READ, 10'd1, 32'd0, 32'd0);
      issue_request(REQ_SET_OCC, 10'd1, 32'd5, 32'd0);
      issue_request(REQ_SET_OCC, 10'd0, 32'h1234_5678, 32'd0);
      issue_request(REQ_SET_OCC, 10'd0, 32'd0, 32'd0);
      issue_request(REQ_SET_EMPTY, 10'd0, 32'hA5A5_A5A5, 32'd0);
      issue_request(REQ_SET_EMPTY, 10'd0, 32'h1, 32'd0);
      issue_request(REQ_DELETE, 10'd1, 32'd0, 32'd0);
      // Set empty past the end grows the used length.
      issue_request(REQ_SET_EMPTY, 10'd9, 32'h8000_0000, 32'd0);
      issue_request(REQ_DELETE, 10'd0, 32'd0, 32'd0);
      issue_request(REQ_ADD, 10'd0, 32'hDEAD_BEEF, 32'd0);
      issue_request(REQ_READ, 10'd9, 32'd0, 32'd0);
      issue_request(REQ_READ, 10'd10, 32'd0, 32'd0);
      issue_request(REQ_READ, 10'd1023, 32'd0, 32'd0);
      issue_request(REQ_SPARE_A, 10'd3, 32'h1, 32'd0);
      issue_request(REQ_SPARE_B, 10'd3, 32'h1, 32'd0);
      issue_request(REQ_DRAW, 10'd0, 32'd0, 32'd0);
   endtask

   task automatic test_draw_modes();
      set_max_in_use(16'd0);
      issue_request(REQ_DRAW, 10'd0, 32'd0, 32'd0);
      issue_request(REQ_DRAW, 10'd0, 32'd0, 32'hFFFF_FFFF);
      issue_request(REQ_DRAW, 10'd0, 32'd0, 32'h8000_0000);
      set_max_in_use(16'hFFFF);
      issue_request(REQ_DRAW, 10'd0, 32'd0, 32'd0);
      issue_request(REQ_DRAW, 10'd0, 32'd0, 32'hFFFF_FFFF);
   endtask

   task automatic test_random_settings();
      set_max_in_use(16'd5);
      run_random_mix(110, 3);
      set_max_in_use(16'd0);
      run_random_mix(100, 3);
      set_max_in_use(16'hFFFF);
      run_random_mix(70, 3);
      set_max_in_use(16'($urandom_range(1, 40)));
      run_random_mix(100, 3);
      set_max_in_use(16'($urandom));
      run_random_mix(30, 3);
   endtask

   task automatic test_fill_to_capacity();
      int guard;
      int zero_slot;
      set_max_in_use(16'd1024);
      guard = 0;
      while ((occ_m < TBL_DEPTH || len_m < TBL_DEPTH) && guard < 1200) begin
         // The first add stores a zero value, so the full table can be left with a zero slot.
         issue_request(REQ_ADD, SLOT_W'($urandom), (guard == 0) ? 32'd0 : pick_value(),
                       $urandom);
         guard++;
      end
      repeat (4) issue_request(REQ_ADD, SLOT_W'($urandom), pick_value(), $urandom);
      issue_request(REQ_SET_EMPTY, 10'd1023, 32'h1, $urandom);
      zero_slot = -1;
      for (int i = 0; i < TBL_DEPTH; i++)
         if (slots_m[i] == '0 && zero_slot < 0) zero_slot = i;
      // Repeated set empty of a zero value drives the count against its ceiling.
      if (zero_slot >= 0)
         repeat (6) issue_request(REQ_SET_EMPTY, zero_slot[SLOT_W-1:0], 32'd0, $urandom);
      repeat (24) issue_request(REQ_DRAW, SLOT_W'($urandom), $urandom, pick_fraction());
   endtask

   task automatic test_full_table_mix();
      run_random_mix(120, 50);
      set_max_in_use(16'($urandom_range(1, 2000)));
      run_random_mix(60, 50);
   endtask

   initial begin
      for (int i = 0; i < TBL_DEPTH; i++) slots_m[i] = '0;
      occ_m        = 0;
      len_m        = 0;
      max_in_use_m = MAX_IN_USE_RESET;
      repeat (11) @(negedge clock);
      reset <= 1'b0;
      test_directed_edges();
      test_draw_modes();
      test_random_settings();
      test_fill_to_capacity();
      test_full_table_mix();
      wait_table_idle();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (err_count == 0 && pending_results.size() == 0) begin
         $display("PASS slot_table_with_random_draw");
      end else begin
         $display("FAIL slot_table_with_random_draw");
      end
      $finish;
   end

endmodule
